[src/remote_switch_pulse_frame_encoder_macros.svh]
// Assertion macros for the remote switch pulse frame encoder.
// Needs nothing beyond the clock and reset names passed in.
`ifndef REMOTE_SWITCH_PULSE_FRAME_ENCODER_MACROS_SVH
`define REMOTE_SWITCH_PULSE_FRAME_ENCODER_MACROS_SVH

// Clocked check, off while reset is high.
`define RSPFE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define RSPFE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/rspfe_pkg.sv]
// Package for the remote switch pulse frame encoder: payload structs,
// symbol and register codes, controller/datapath command and status types.
package rspfe_pkg;

   localparam int ADDRESS_BITS = 27;
   localparam int SYM_IDX_W    = $clog2(ADDRESS_BITS + 11);
   localparam int TICK_W       = 15;
   localparam int US_W         = 16;
   localparam int RATE_W       = 8;
   localparam int CSR_IDX_W    = 3;
   localparam int NUM_TICKS    = 5;
   localparam int TICK_SEL_W   = 3;

   // symbol kinds
   localparam logic [2:0] KIND_START = 3'd0;
   localparam logic [2:0] KIND_ONE   = 3'd1;
   localparam logic [2:0] KIND_ZERO  = 3'd2;
   localparam logic [2:0] KIND_DIM   = 3'd3;
   localparam logic [2:0] KIND_STOP  = 3'd4;

   // register indexes, also the slots of the converted tick table
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_HIGH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_LOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_START_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_LOW   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TICK_RATE  = 3'd5;

   localparam logic [TICK_W-1:0] TICK_MAX = 15'd32767;

   typedef struct packed {
      logic [31:0] address_word;
      logic        switch_on;
      logic [3:0]  unit_number;
      logic [3:0]  dim_level;
   } req_type;

   typedef struct packed {
      logic [2:0]        symbol_kind;
      logic [1:0]        pair_count;
      logic [TICK_W-1:0] first_high_ticks;
      logic [TICK_W-1:0] first_low_ticks;
      logic [TICK_W-1:0] second_high_ticks;
      logic [TICK_W-1:0] second_low_ticks;
      logic              frame_end;
   } rsp_type;

   typedef struct packed {
      logic [US_W-1:0]   short_high_us;
      logic [US_W-1:0]   short_low_us;
      logic [US_W-1:0]   long_low_us;
      logic [US_W-1:0]   start_low_us;
      logic [US_W-1:0]   stop_low_us;
      logic [RATE_W-1:0] ticks_per_10us;
   } cfg_type;

   typedef struct packed {
      logic load;   // latch command, start tick conversion
      logic emit;   // register next symbol into the output stage
   } dp_cmd_type;

   typedef struct packed {
      logic conv_done;
      logic out_free;
      logic last_sym;
   } dp_status_type;

endpackage

[src/rspfe_csr.sv]
// Configuration registers of the frame encoder.
// Uses rspfe_pkg for register codes and the cfg_type struct.
module rspfe_csr
   import rspfe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [US_W-1:0]      wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_SHORT_HIGH: cfg_in.short_high_us  = wr_data;
            REG_SHORT_LOW:  cfg_in.short_low_us   = wr_data;
            REG_LONG_LOW:   cfg_in.long_low_us    = wr_data;
            REG_START_LOW:  cfg_in.start_low_us   = wr_data;
            REG_STOP_LOW:   cfg_in.stop_low_us    = wr_data;
            REG_TICK_RATE:  cfg_in.ticks_per_10us = wr_data[RATE_W-1:0];
            default: ;  // unknown index ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_high_us  <= 16'd221;
         cfg_ff.short_low_us   <= 16'd321;
         cfg_ff.long_low_us    <= 16'd1331;
         cfg_ff.start_low_us   <= 16'd2724;
         cfg_ff.stop_low_us    <= 16'd10320;
         cfg_ff.ticks_per_10us <= 8'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/rspfe_ctrl.sv]
// Controller state machine of the frame encoder.
// Uses rspfe_pkg for the datapath command and status structs.
module rspfe_ctrl
   import rspfe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CONV = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            if (status.conv_done) state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = status.out_free;
            if (status.out_free && status.last_sym) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/rspfe_dp.sv]
// Datapath of the frame encoder: command hold, microsecond-to-tick
// converter, symbol assembly and output register. Uses rspfe_pkg.
module rspfe_dp
   import rspfe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  req_type       req_payload,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_payload
);

   localparam logic [SYM_IDX_W-1:0] IDX_FLAG      = SYM_IDX_W'(ADDRESS_BITS + 1);
   localparam logic [SYM_IDX_W-1:0] IDX_UNIT_LAST = SYM_IDX_W'(ADDRESS_BITS + 5);
   localparam logic [SYM_IDX_W-1:0] IDX_DIM_LAST  = SYM_IDX_W'(ADDRESS_BITS + 9);
   localparam logic [SYM_IDX_W-1:0] IDX_STOP_ON   = SYM_IDX_W'(ADDRESS_BITS + 6);
   localparam logic [SYM_IDX_W-1:0] IDX_STOP_DIM  = SYM_IDX_W'(ADDRESS_BITS + 10);
   localparam logic [SYM_IDX_W-1:0] IDX_ADDR_LAST = SYM_IDX_W'(ADDRESS_BITS);
   localparam logic [TICK_SEL_W-1:0] SEL_LAST    = TICK_SEL_W'(NUM_TICKS - 1);
   localparam logic [16:0] RECIP_10 = 17'd52429;  // x/10 == (x*52429)>>19 for 16-bit x

   // held command
   logic [31:0]          addr_sh_ff;
   logic [3:0]           unit_sh_ff;
   logic [3:0]           dim_sh_ff;
   logic                 on_ff;
   logic                 dim_nz_ff;
   logic [SYM_IDX_W-1:0] idx_ff;

   // converter
   logic                  conv_busy_ff;
   logic [TICK_SEL_W-1:0] conv_cnt_ff;
   logic                  s1_valid_ff;
   logic [TICK_SEL_W-1:0] s1_sel_ff;
   logic [12:0]           quot_ff;
   logic [TICK_W-1:0]     ticks_ff [NUM_TICKS];
   logic [US_W-1:0]       conv_us;
   logic [32:0]           recip_prod;
   logic [20:0]           rate_prod;
   logic [TICK_W-1:0]     tick_sat;

   // output stage
   logic    rsp_valid_ff;
   rsp_type rsp_ff, sym;
   logic    is_addr, is_flag, is_unit, is_dimb, is_stop, bit_val;

   // ---------------- converter: divide by ten, then scale by the rate
   always_comb begin
      case (conv_cnt_ff)
         REG_SHORT_HIGH: conv_us = cfg.short_high_us;
         REG_SHORT_LOW:  conv_us = cfg.short_low_us;
         REG_LONG_LOW:   conv_us = cfg.long_low_us;
         REG_START_LOW:  conv_us = cfg.start_low_us;
         default:        conv_us = cfg.stop_low_us;
      endcase
   end

   assign recip_prod = 33'(conv_us) * 33'(RECIP_10);
   assign rate_prod  = 21'(quot_ff) * 21'(cfg.ticks_per_10us);
   assign tick_sat   = (rate_prod > 21'(TICK_MAX)) ? TICK_MAX : rate_prod[TICK_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_busy_ff <= 1'b0;
         conv_cnt_ff  <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= conv_busy_ff;
         if (cmd.load) begin
            conv_busy_ff <= 1'b1;
            conv_cnt_ff  <= '0;
         end else if (conv_busy_ff) begin
            conv_cnt_ff <= conv_cnt_ff + 1'b1;
            if (conv_cnt_ff == SEL_LAST) conv_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_sel_ff <= conv_cnt_ff;
      quot_ff   <= recip_prod[31:19];
      if (s1_valid_ff) ticks_ff[s1_sel_ff] <= tick_sat;
   end

   // ---------------- symbol decode
   assign is_addr = (idx_ff != '0) && (idx_ff <= IDX_ADDR_LAST);
   assign is_flag = (idx_ff == IDX_FLAG);
   assign is_unit = (idx_ff > IDX_FLAG) && (idx_ff <= IDX_UNIT_LAST);
   assign is_dimb = dim_nz_ff && (idx_ff > IDX_UNIT_LAST) && (idx_ff <= IDX_DIM_LAST);
   assign is_stop = (idx_ff == (dim_nz_ff ? IDX_STOP_DIM : IDX_STOP_ON));

   always_comb begin
      bit_val = dim_sh_ff[3];
      if (is_addr)      bit_val = addr_sh_ff[31];
      else if (is_flag) bit_val = on_ff;
      else if (is_unit) bit_val = unit_sh_ff[3];

      if (idx_ff == '0)                 sym.symbol_kind = KIND_START;
      else if (is_flag && dim_nz_ff)    sym.symbol_kind = KIND_DIM;
      else if (is_addr || is_flag || is_unit || is_dimb)
                                        sym.symbol_kind = bit_val ? KIND_ONE : KIND_ZERO;
      else                              sym.symbol_kind = KIND_STOP;

      sym.pair_count        = 2'd2;
      sym.first_high_ticks  = ticks_ff[REG_SHORT_HIGH];
      sym.first_low_ticks   = ticks_ff[REG_SHORT_LOW];
      sym.second_high_ticks = ticks_ff[REG_SHORT_HIGH];
      sym.second_low_ticks  = ticks_ff[REG_SHORT_LOW];
      sym.frame_end         = (sym.symbol_kind == KIND_STOP);
      case (sym.symbol_kind)
         KIND_START, KIND_STOP: begin
            sym.pair_count        = 2'd1;
            sym.first_low_ticks   = (sym.symbol_kind == KIND_START) ?
                                    ticks_ff[REG_START_LOW] : ticks_ff[REG_STOP_LOW];
            sym.second_high_ticks = '0;
            sym.second_low_ticks  = '0;
         end
         KIND_ONE:  sym.first_low_ticks  = ticks_ff[REG_LONG_LOW];
         KIND_ZERO: sym.second_low_ticks = ticks_ff[REG_LONG_LOW];
         default: ;
      endcase
   end

   // ---------------- command hold and symbol counter
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_sh_ff <= req_payload.address_word;
         unit_sh_ff <= req_payload.unit_number;
         dim_sh_ff  <= req_payload.dim_level;
         on_ff      <= req_payload.switch_on;
         dim_nz_ff  <= (req_payload.dim_level != 4'd0);
         idx_ff     <= '0;
      end else if (cmd.emit) begin
         idx_ff <= idx_ff + 1'b1;
         if (is_addr) addr_sh_ff <= {addr_sh_ff[30:0], 1'b0};
         if (is_unit) unit_sh_ff <= {unit_sh_ff[2:0], 1'b0};
         if (is_dimb) dim_sh_ff  <= {dim_sh_ff[2:0], 1'b0};
      end
   end

   // ---------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_ff <= sym;
   end

   assign status.conv_done = s1_valid_ff && (s1_sel_ff == SEL_LAST);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.last_sym  = is_stop;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload      = rsp_ff;

endmodule

[src/remote_switch_pulse_frame_encoder.sv]
// Remote switch pulse frame encoder, top level.
// After a command is accepted, the first symbol beat follows the tick conversions
// (5 tick conversions through one shared two-multiplier converter, then the output register).
// Throughput: one symbol per cycle while rsp_ready is high; a new command waits for the stop beat.
// Reset: synchronous, active high; registers return to defaults, encoder idle, no beat pending.
`include "remote_switch_pulse_frame_encoder_macros.svh"
module remote_switch_pulse_frame_encoder
   import rspfe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // command channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_payload,
   // symbol channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_payload,
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [US_W-1:0]      csr_data
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // registers always writable; by contract writes land only while idle, block does not enforce it
   assign csr_ready = 1'b1;

   rspfe_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // sequencer: idle -> convert durations -> emit symbols
   rspfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // converter, symbol builder and output beat register
   rspfe_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // one command at a time: no second accept straight after the first
   `RSPFE_ASSERT(a_one_cmd, clock, reset, (req_valid && req_ready) |=> !req_ready, "back-to-back accept")
   // start and stop beats carry exactly one pair
   `RSPFE_ASSERT(a_single_pair, clock, reset, (rsp_valid && (rsp_payload.symbol_kind == KIND_START || rsp_payload.symbol_kind == KIND_STOP)) |-> (rsp_payload.pair_count == 2'd1 && rsp_payload.second_high_ticks == '0 && rsp_payload.second_low_ticks == '0), "single-pair symbol malformed")
   // frame_end marks the stop beat and nothing else
   `RSPFE_ASSERT(a_frame_end, clock, reset, rsp_valid |-> (rsp_payload.frame_end == (rsp_payload.symbol_kind == KIND_STOP)), "frame_end mismatch")
   // controller only emits into a free output stage
   `RSPFE_ASSERT_ALWAYS(a_no_overrun, clock, cmd.emit |-> status.out_free, "emit into full output stage")

endmodule
